// ===== rtl/modular_exponentiation_unit_defines.svh =====
// ----------------------------------------------------------------------------
// modular exponentiation unit assertion macros
// shared property wrappers, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH
`define MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH

// same-cycle implication
`define MEU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("modexp assertion failed");

// next-cycle implication
`define MEU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("modexp assertion failed");

`endif

// ===== rtl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// modular exponentiation package
// field widths, parameter defaults and the multiplier control structs
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int unsigned BASE_W       = 32;
  localparam int unsigned POW_W        = 31;
  localparam int unsigned MOD_W        = 31;
  localparam int unsigned CNT_W        = $clog2(BASE_W + 1);
  localparam int unsigned EXP_BITS_DEF = 32;
  localparam int unsigned MOD_BITS_DEF = 31;

  localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] nbits;
  } mm_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_rsp_t;

endpackage

// ===== rtl/mexp_modmul.sv =====
// ----------------------------------------------------------------------------
// bit-serial modular multiplier
// scans the left-aligned x operand one bit per cycle, msb first, doubling the
// partial result, adding y on set bits, then folding it back below the modulus
// ----------------------------------------------------------------------------
`include "modular_exponentiation_unit_defines.svh"

module mexp_modmul #(
  parameter int unsigned MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mexp_pkg::mm_req_t            req,
  input  logic [mexp_pkg::BASE_W-1:0]  x,
  input  logic [MOD_BITS-1:0]          y,
  input  logic [MOD_BITS-1:0]          m,
  output mexp_pkg::mm_rsp_t            rsp,
  output logic [MOD_BITS-1:0]          p
);
  import mexp_pkg::*;

  localparam int unsigned SUM_W = MOD_BITS + 2;

  logic [MOD_BITS-1:0] acc_r;
  logic [BASE_W-1:0]   x_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic                done_r;

  logic [SUM_W-1:0]    sum;
  logic [SUM_W:0]      diff1;
  logic [SUM_W:0]      diff2;
  logic [MOD_BITS-1:0] acc_nxt;

  // doubled partial plus addend stays below three times the modulus
  assign sum   = {1'b0, acc_r, 1'b0} + (x_r[BASE_W-1] ? SUM_W'(y) : '0);
  assign diff1 = {1'b0, sum} - (SUM_W + 1)'(m);
  assign diff2 = {1'b0, sum} - (SUM_W + 1)'({m, 1'b0});

  always_comb begin
    if (!diff2[SUM_W]) begin
      acc_nxt = diff2[MOD_BITS-1:0];
    end else if (!diff1[SUM_W]) begin
      acc_nxt = diff1[MOD_BITS-1:0];
    end else begin
      acc_nxt = sum[MOD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        acc_r  <= '0;
        x_r    <= x;
        cnt_r  <= req.nbits;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        x_r   <= {x_r[BASE_W-2:0], 1'b0};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign p        = acc_r;

  `MEU_ASSERT_IMP(a_no_restart, req.start, !busy_r && !done_r)
  `MEU_ASSERT_IMP(a_done_idle, done_r, !busy_r)
  `MEU_ASSERT_IMP(a_res_reduced, done_r, acc_r < m)

endmodule

// ===== rtl/modular_exponentiation_unit.sv =====
// ----------------------------------------------------------------------------
// modular exponentiation unit
// base to the exponent modulo the configured modulus by square and multiply
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. The base is first
// reduced, then each exponent bit from the top costs one modular square and,
// where the bit is set, one modular multiply, each run in the bit-serial
// multiplier. The next item can be taken at the edge that takes the result.
// The result shows on out_power for one cycle,
// flagged by out_valid, and must be taken then: there is no back-pressure.
// The modulus is written through the cfg port while busy is low; zero acts
// as one.
`include "modular_exponentiation_unit_defines.svh"

module modular_exponentiation_unit #(
  parameter int unsigned EXP_BITS = mexp_pkg::EXP_BITS_DEF,
  parameter int unsigned MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [mexp_pkg::BASE_W-1:0]  in_base,
  input  logic [mexp_pkg::BASE_W-1:0]  in_exponent,
  output logic                         out_valid,
  output logic [mexp_pkg::POW_W-1:0]   out_power,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mexp_pkg::MOD_W-1:0]   cfg_modulus
);
  import mexp_pkg::*;

  localparam int unsigned ECNT_W = $clog2(EXP_BITS + 1);
  localparam int unsigned PAD_W  = BASE_W - MOD_BITS;

  typedef enum logic [1:0] {S_IDLE, S_BASE, S_SQR, S_MUL} state_t;

  state_t              state_r;
  logic [MOD_BITS-1:0] mod_r;
  logic [MOD_BITS-1:0] b_r;
  logic [EXP_BITS-1:0] exp_r;
  logic [ECNT_W-1:0]   ecnt_r;
  logic [BASE_W-1:0]   x_op_r;
  logic [MOD_BITS-1:0] y_op_r;
  logic [CNT_W-1:0]    nbits_r;
  logic                mm_start_r;
  logic                out_valid_r;
  logic [POW_W-1:0]    out_power_r;

  logic [MOD_BITS-1:0] m_eff;
  logic [MOD_BITS-1:0] one_mod;
  logic [MOD_BITS-1:0] mm_p;
  logic                last;
  mm_req_t             mm_req;
  mm_rsp_t             mm_rsp;

  assign m_eff   = (mod_r == '0) ? MOD_BITS'(1) : mod_r;
  assign one_mod = (m_eff == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
  assign last    = (ecnt_r == ECNT_W'(1));

  assign mm_req.start = mm_start_r;
  assign mm_req.nbits = nbits_r;

  mexp_modmul #(
    .MOD_BITS (MOD_BITS)
  ) u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .x     (x_op_r),
    .y     (y_op_r),
    .m     (m_eff),
    .rsp   (mm_rsp),
    .p     (mm_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mm_start_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mod_r       <= MOD_RESET[MOD_BITS-1:0];
    end else begin
      mm_start_r  <= 1'b0;
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        mod_r <= cfg_modulus[MOD_BITS-1:0];
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            x_op_r     <= in_base;
            y_op_r     <= MOD_BITS'(1);
            nbits_r    <= CNT_W'(BASE_W);
            mm_start_r <= 1'b1;
            exp_r      <= EXP_BITS'(in_exponent);
            ecnt_r     <= ECNT_W'(EXP_BITS);
            state_r    <= S_BASE;
          end
        end
        S_BASE: begin
          if (mm_rsp.done) begin
            b_r        <= mm_p;
            x_op_r     <= {one_mod, {PAD_W{1'b0}}};
            y_op_r     <= one_mod;
            nbits_r    <= CNT_W'(MOD_BITS);
            mm_start_r <= 1'b1;
            state_r    <= S_SQR;
          end
        end
        S_SQR: begin
          if (mm_rsp.done) begin
            if (exp_r[EXP_BITS-1]) begin
              x_op_r     <= {mm_p, {PAD_W{1'b0}}};
              y_op_r     <= b_r;
              mm_start_r <= 1'b1;
              state_r    <= S_MUL;
            end else if (last) begin
              out_power_r <= POW_W'(mm_p);
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              exp_r      <= {exp_r[EXP_BITS-1:0]} << 1;
              ecnt_r     <= ecnt_r - ECNT_W'(1);
              x_op_r     <= {mm_p, {PAD_W{1'b0}}};
              y_op_r     <= mm_p;
              mm_start_r <= 1'b1;
            end
          end
        end
        S_MUL: begin
          if (mm_rsp.done) begin
            if (last) begin
              out_power_r <= POW_W'(mm_p);
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              exp_r      <= {exp_r[EXP_BITS-1:0]} << 1;
              ecnt_r     <= ecnt_r - ECNT_W'(1);
              x_op_r     <= {mm_p, {PAD_W{1'b0}}};
              y_op_r     <= mm_p;
              mm_start_r <= 1'b1;
              state_r    <= S_SQR;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign out_valid = out_valid_r;
  assign out_power = out_power_r;

  `MEU_ASSERT_NEXT(a_accept_busy, start && !busy, busy && mm_start_r)
  `MEU_ASSERT_IMP(a_out_reduced, out_valid, out_power < POW_W'(m_eff))
  `MEU_ASSERT_IMP(a_out_idle, out_valid, !busy && !mm_rsp.busy)

endmodule

// ===== tb/sv/tb_modular_exponentiation_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular exponentiation unit testbench
// Drives base and exponent commands through the start/busy handshake and
// checks every out_power strobe against a square-and-multiply predictor
// that tracks the modulus register. The run covers corner bases and
// exponents, then random phases under several moduli, 0, 1, 2 and 2^31-1
// among them, with varying sender gaps between transfers.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation_unit;

  localparam int unsigned BASE_W = mexp_pkg::BASE_W;
  localparam int unsigned POW_W  = mexp_pkg::POW_W;
  localparam int unsigned MOD_W  = mexp_pkg::MOD_W;
  localparam int unsigned E_BITS = mexp_pkg::EXP_BITS_DEF;

  class power_checker;
    logic [MOD_W-1:0] modulus;
    logic [POW_W-1:0] expected_powers[$];
    int               errors;
    int               checked;

    function new();
      modulus = mexp_pkg::MOD_RESET;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_modulus(logic [MOD_W-1:0] value);
      modulus = value;
    endfunction

    function logic [POW_W-1:0] compute_power(logic [BASE_W-1:0] base,
                                             logic [BASE_W-1:0] exponent);
      logic [63:0] m;
      logic [63:0] b;
      logic [63:0] acc;
      m = 64'(modulus);
      if (m == 0) begin
        m = 64'd1;
      end
      b   = 64'(base) % m;
      acc = 64'd1 % m;
      for (int i = E_BITS - 1; i >= 0; i--) begin
        acc = (acc * acc) % m;
        if (exponent[i]) begin
          acc = (acc * b) % m;
        end
      end
      return acc[POW_W-1:0];
    endfunction

    function void note_item(logic [BASE_W-1:0] base, logic [BASE_W-1:0] exponent);
      expected_powers.insert(expected_powers.size(), compute_power(base, exponent));
    endfunction

    function void check_power(logic [POW_W-1:0] actual);
      logic [POW_W-1:0] want;
      if (expected_powers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, actual);
        errors++;
        return;
      end
      want = expected_powers.pop_front();
      checked++;
      if (want !== actual) begin
        $display("%0t: power mismatch, expected %0d, actual %0d", $time, want, actual);
        errors++;
      end
    endfunction

    function int pending();
      return expected_powers.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [BASE_W-1:0] in_base;
  logic [BASE_W-1:0] in_exponent;
  logic              out_valid;
  logic [POW_W-1:0]  out_power;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [MOD_W-1:0]  cfg_modulus;

  power_checker sb;
  int           n_items;
  int           n_writes;

  modular_exponentiation_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_base     (in_base),
    .in_exponent (in_exponent),
    .out_valid   (out_valid),
    .out_power   (out_power),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_modulus (cfg_modulus)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_power(out_power);
    end
  end

  // holds the command until the transfer, returns on the accepting edge
  task automatic send_item(logic [BASE_W-1:0] b, logic [BASE_W-1:0] e);
    in_base     <= b;
    in_exponent <= e;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_item(b, e);
    n_items++;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_modulus(logic [MOD_W-1:0] value);
    drain();
    cfg_valid   <= 1'b1;
    cfg_modulus <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_modulus(value);
    cfg_valid <= 1'b0;
    n_writes++;
  endtask

  initial begin
    #60_000_000;
    $display("tb_modular_exponentiation_unit: done, errors");
    $finish;
  end

  initial begin
    int                n;
    int                pct;
    int                gap;
    logic [BASE_W-1:0] b;
    logic [BASE_W-1:0] e;
    logic [MOD_W-1:0]  m;
    sb          = new();
    n_items     = 0;
    n_writes    = 0;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_base     <= '0;
    in_exponent <= '0;
    cfg_valid   <= 1'b0;
    cfg_modulus <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner cases under the reset modulus
    send_item(32'd0, 32'd0);
    send_item(32'd0, 32'd1);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'd1, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'd0);
    send_item(32'd2, 32'd31);
    send_item(32'd1000000007, 32'd5);
    send_item(32'd1000000006, 32'd2);
    send_item(32'd3, 32'h8000_0000);
    send_item(32'd7, 32'h5555_5555);
    send_item(32'd7, 32'hAAAA_AAAA);
    send_item(32'd12345, 32'd1);
    start <= 1'b0;

    // modulus of one
    write_modulus(31'd1);
    send_item(32'd5, 32'd0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    start <= 1'b0;

    // zero modulus acts as one
    write_modulus(31'd0);
    send_item(32'd0, 32'd0);
    send_item(32'd9, 32'd3);
    start <= 1'b0;

    write_modulus(31'h7FFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'h7FFF_FFFF, 32'd2);
    send_item(32'h7FFF_FFFE, 32'd3);
    send_item(32'd2, 32'd30);
    start <= 1'b0;

    write_modulus(31'd2);
    send_item(32'd3, 32'd0);
    send_item(32'hFFFF_FFFE, 32'd1);
    start <= 1'b0;

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: m = 31'h7FFF_FFFF;
        1: m = 31'd1;
        2: m = 31'($urandom_range(2, 32'h7FFF_FFFF));
        3: m = 31'd2;
        4: m = 31'($urandom_range(3, 1000));
        5: m = 31'd0;
        6: m = mexp_pkg::MOD_RESET;
        7: m = 31'($urandom());
        default: m = 31'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
      endcase
      write_modulus(m);
      n = (m <= 31'd1) ? 12 : 35;
      case (p % 3)
        0: pct = 0;
        1: pct = 69;
        default: pct = 25;
      endcase
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 3))
          0: b = $urandom();
          1: b = $urandom_range(0, 3);
          2: b = 32'(sb.modulus) + $urandom_range(0, 2) - 32'd1;
          default: b = $urandom() | 32'hFFFF_0000;
        endcase
        case ($urandom_range(0, 3))
          0, 1: e = $urandom();
          2: e = $urandom_range(0, 40);
          default: e = $urandom() | $urandom();
        endcase
        send_item(b, e);
        if (i == n - 1 || $urandom_range(0, 39) == 0) begin
          start <= 1'b0;
          drain();
        end else if ($urandom_range(0, 99) < pct) begin
          start <= 1'b0;
          gap = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(9, 2300);
          repeat (gap) @(posedge clk);
        end
      end
    end

    drain();
    repeat (2200) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d results missing, expected %0d more, actual 0", $time,
               sb.pending(), sb.pending());
      sb.errors++;
    end
    $display("covered %0d commands and %0d checked powers over %0d modulus writes",
             n_items, sb.checked, n_writes);
    $display("moduli 0, 1, 2 and 2^31-1 included, sender gaps at 0, 25 and 69 percent");
    if (sb.errors == 0) begin
      $display("tb_modular_exponentiation_unit: done, clean");
    end else begin
      $display("tb_modular_exponentiation_unit: done, errors");
    end
    $finish;
  end

endmodule
